@@ rtl/tsr_pkg.sv @@
package tsr_pkg;

	localparam int unsigned IDX_W      = 64;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned HELD_W     = 7;
	localparam int unsigned RES_W      = 7;
	localparam int unsigned MAXRES     = 64;
	localparam int unsigned IN_TDATA_W = 80;
	localparam int unsigned IN_TUSER_W = 3;

	// tuser bit positions on the slave side
	localparam int unsigned TU_FIRST  = 0;
	localparam int unsigned TU_NODATA = 1;
	localparam int unsigned TU_EOF    = 2;

	typedef struct packed {
		logic load_in;
		logic set_limit;
		logic store;
		logic clr_cnt;
		logic emit_byte;
		logic emit_end;
	} tsr_cmd_t;

	typedef struct packed {
		logic can_emit;
		logic end_ready;
		logic out_free;
		logic seg_last;
	} tsr_stat_t;

endpackage

@@ rtl/tsr_ctrl.sv @@
module tsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tsr_pkg::tsr_stat_t stat,
	output tsr_pkg::tsr_cmd_t  cmd
);
	import tsr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIMIT,
		ST_STORE,
		ST_REL_CHK,
		ST_EMIT,
		ST_END
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load_in   = in_valid && (state_q == ST_IDLE);
		cmd.set_limit = (state_q == ST_LIMIT);
		cmd.store     = (state_q == ST_STORE);
		cmd.clr_cnt   = (state_q == ST_STORE);
		cmd.emit_byte = (state_q == ST_EMIT) && stat.out_free;
		cmd.emit_end  = (state_q == ST_END) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_LIMIT;
				end
				ST_LIMIT: begin
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					state_q <= stat.seg_last ? ST_REL_CHK : ST_IDLE;
				end
				ST_REL_CHK: begin
					priority if (stat.can_emit) state_q <= ST_EMIT;
					else if (stat.end_ready)    state_q <= ST_END;
					else                        state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (stat.out_free) state_q <= ST_REL_CHK;
				end
				ST_END: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/tsr_datapath.sv @@
module tsr_datapath #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsr_pkg::tsr_cmd_t           cmd,
	output tsr_pkg::tsr_stat_t          stat,
	input  logic [tsr_pkg::IDX_W-1:0]   byte_index,
	input  logic [tsr_pkg::BYTE_W-1:0]  byte_value,
	input  logic                        first_of_segment,
	input  logic                        last_of_segment,
	input  logic                        no_data,
	input  logic                        eof_flag,
	input  logic [tsr_pkg::HELD_W-1:0]  stream_held,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tsr_pkg::BYTE_W-1:0]  out_byte,
	output logic                        is_end,
	output logic                        last
);
	import tsr_pkg::*;

	localparam int unsigned SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

	// input transaction held for the duration of the item
	logic [IDX_W-1:0]  idx_s1;
	logic [BYTE_W-1:0] val_s1;
	logic              first_s1;
	logic              last_s1;
	logic              nodata_s1;
	logic              eof_s1;
	logic [HELD_W-1:0] held_s1;

	logic [IDX_W-1:0]  next_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic [IDX_W-1:0]  limit_q;
	logic              end_known_q;
	logic [IDX_W-1:0]  end_q;
	logic              closed_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] rd_q;

	logic [BYTE_W-1:0] mem [CAPACITY];

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_end_q;
	logic              out_last_q;

	// window limit
	logic [HELD_W-1:0] room;
	logic [IDX_W:0]    lim_sum;
	logic [IDX_W-1:0]  lim_sat;

	// store slot
	logic              in_win;
	logic [IDX_W-1:0]  offset;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] wr_slot;

	// end position
	logic [IDX_W-1:0]  end_new;

	// release
	logic [SLOT_W-1:0] slot_inc;
	logic [IDX_W:0]    next_inc;
	logic [RES_W-1:0]  cnt_ext;
	logic              more_after;
	logic              end_after;

	always_comb begin
		room    = (held_s1 >= HELD_W'(CAPACITY)) ? '0 : HELD_W'(CAPACITY) - held_s1;
		lim_sum = {1'b0, next_q} + {{(IDX_W + 1 - HELD_W){1'b0}}, room};
		lim_sat = lim_sum[IDX_W] ? '1 : lim_sum[IDX_W-1:0];
	end

	always_comb begin
		in_win   = !nodata_s1 && (idx_s1 >= next_q) && (idx_s1 < limit_q);
		offset   = idx_s1 - next_q;
		slot_sum = {1'b0, next_slot_q} + {1'b0, offset[SLOT_W-1:0]};
		wr_slot  = (slot_sum >= (SLOT_W + 1)'(CAPACITY)) ?
		           SLOT_W'(slot_sum - (SLOT_W + 1)'(CAPACITY)) : slot_sum[SLOT_W-1:0];
		end_new  = nodata_s1 ? idx_s1 : ((idx_s1 == '1) ? '1 : idx_s1 + 1'b1);
	end

	always_comb begin
		slot_inc   = (next_slot_q == SLOT_W'(CAPACITY - 1)) ? '0 : next_slot_q + 1'b1;
		next_inc   = {1'b0, next_q} + 1'b1;
		cnt_ext    = RES_W'(cnt_q);
		more_after = valid_q[slot_inc] && (cnt_q < CNT_W'(CAPACITY - 1));
		end_after  = end_known_q && !closed_q && (next_inc >= {1'b0, end_q}) &&
		             ((cnt_ext + 1'b1) < RES_W'(MAXRES));
	end

	always_comb begin
		stat.can_emit  = valid_q[next_slot_q] && (cnt_q < CNT_W'(CAPACITY));
		stat.end_ready = end_known_q && !closed_q && (next_q >= end_q) &&
		                 (cnt_ext < RES_W'(MAXRES));
		stat.out_free  = !out_valid_q || out_ready;
		stat.seg_last  = last_s1;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign is_end    = out_end_q;
	assign last      = out_last_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			idx_s1    <= byte_index;
			val_s1    <= byte_value;
			first_s1  <= first_of_segment;
			last_s1   <= last_of_segment;
			nodata_s1 <= no_data;
			eof_s1    <= eof_flag;
			held_s1   <= stream_held;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && in_win && !valid_q[wr_slot]) begin
			mem[wr_slot] <= val_s1;
		end
		rd_q <= mem[next_slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q      <= '0;
			next_slot_q <= '0;
			limit_q     <= '0;
			end_known_q <= 1'b0;
			end_q       <= '0;
			closed_q    <= 1'b0;
			valid_q     <= '0;
			cnt_q       <= '0;
		end else begin
			if (cmd.set_limit && first_s1) begin
				limit_q <= lim_sat;
			end
			if (cmd.store) begin
				if (in_win) valid_q[wr_slot] <= 1'b1;
				if (last_s1 && eof_s1) begin
					end_known_q <= 1'b1;
					end_q       <= end_new;
				end
			end
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end
			if (cmd.emit_byte) begin
				valid_q[next_slot_q] <= 1'b0;
				next_q               <= next_inc[IDX_W-1:0];
				next_slot_q          <= slot_inc;
				cnt_q                <= cnt_q + 1'b1;
			end
			if (cmd.emit_end) begin
				closed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if (cmd.emit_byte || cmd.emit_end) out_valid_q <= 1'b1;
			else if (out_ready)                         out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_byte) begin
			out_byte_q <= rd_q;
			out_end_q  <= 1'b0;
			out_last_q <= !more_after && !end_after;
		end else if (cmd.emit_end) begin
			out_byte_q <= '0;
			out_end_q  <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

endmodule

@@ rtl/tcp_stream_reassembler_core.sv @@
// Reassembles an out-of-order byte stream delivered one byte per transaction, each byte
// tagged with its absolute stream index. Bytes inside the receive window are parked in a
// CAPACITY-entry byte store; on the tlast transaction of a segment the contiguous run from
// the next expected index is released in order, followed by a single end-of-stream notice
// (tuser set) once the end position is reached. An input transaction passes the idle,
// limit and store states; a tlast transaction adds a release check, then an emit state
// and a new check per released byte and an end state for a notice; emit and end wait
// on m_axis_tready while the output register is full. The release walk reads the byte
// store via its single registered read port, one slot at a time. tready is low mid-item.
module tcp_stream_reassembler_core #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// byte_index, byte_value, stream_held, zero pad
	input  logic [tsr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// first_of_segment, no_data, eof_flag
	input  logic [tsr_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_byte
	output logic [tsr_pkg::BYTE_W-1:0]        m_axis_tdata,
	// is_end
	output logic [0:0]                        m_axis_tuser,
	output logic                              m_axis_tlast
);
	import tsr_pkg::*;

	tsr_cmd_t  cmd;
	tsr_stat_t stat;
	logic      is_end;

	tsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tsr_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.byte_index       (s_axis_tdata[IDX_W-1:0]),
		.byte_value       (s_axis_tdata[IDX_W +: BYTE_W]),
		.first_of_segment (s_axis_tuser[TU_FIRST]),
		.last_of_segment  (s_axis_tlast),
		.no_data          (s_axis_tuser[TU_NODATA]),
		.eof_flag         (s_axis_tuser[TU_EOF]),
		.stream_held      (s_axis_tdata[IDX_W + BYTE_W +: HELD_W]),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_byte         (m_axis_tdata),
		.is_end           (is_end),
		.last             (m_axis_tlast)
	);

	assign m_axis_tuser[0] = is_end;

endmodule

@@ tb/sv/tsr_checker.sv @@
module tsr_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [tsr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic [tsr_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	input  logic                           s_axis_tlast,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [tsr_pkg::BYTE_W-1:0]     m_axis_tdata,
	input  logic [0:0]                     m_axis_tuser,
	input  logic                           m_axis_tlast,
	output int                             mismatches,
	output int                             awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	import tsr_pkg::*;

	localparam int SLOTS   = 64;
	localparam int VAL_LO  = IDX_W;
	localparam int HELD_LO = IDX_W + BYTE_W;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              is_end;
		logic              last;
	} stream_out_t;

	stream_out_t       out_due [$];
	logic [BYTE_W-1:0] slot_byte [SLOTS];
	bit                slot_full [SLOTS];
	logic [IDX_W-1:0]  next_pos;
	logic [IDX_W-1:0]  win_limit;
	logic [IDX_W-1:0]  end_pos;
	bit                end_known;
	bit                closed;

	task automatic log_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic reassemble(
		input logic [IDX_W-1:0]  idx,
		input logic [BYTE_W-1:0] val,
		input bit                first,
		input bit                seg_end,
		input bit                no_byte,
		input bit                eof,
		input logic [HELD_W-1:0] held
	);
		logic [IDX_W:0] sum;
		int             n;
		stream_out_t    pend;
		bit             have;
		n = 0;
		have = 1'b0;
		pend = '0;
		if (first) begin
			sum = {1'b0, next_pos} + ((held >= SLOTS) ? 0 : SLOTS - held);
			win_limit = sum[IDX_W] ? '1 : sum[IDX_W-1:0];
		end
		if (!no_byte && idx >= next_pos && idx < win_limit && !slot_full[idx[5:0]]) begin
			slot_byte[idx[5:0]] = val;
			slot_full[idx[5:0]] = 1'b1;
		end
		if (!seg_end)
			return;
		if (eof) begin
			end_known = 1'b1;
			end_pos = (no_byte || &idx) ? idx : idx + 1'b1;
		end
		// in-order release from the next expected position
		while (n < MAXRES && slot_full[next_pos[5:0]]) begin
			if (have)
				out_due.push_back(pend);
			pend = '{data: slot_byte[next_pos[5:0]], is_end: 1'b0, last: 1'b0};
			have = 1'b1;
			slot_full[next_pos[5:0]] = 1'b0;
			next_pos++;
			n++;
		end
		if (end_known && !closed && next_pos >= end_pos && n < MAXRES) begin
			if (have)
				out_due.push_back(pend);
			pend = '{data: '0, is_end: 1'b1, last: 1'b0};
			have = 1'b1;
			closed = 1'b1;
		end
		if (have) begin
			pend.last = 1'b1;
			out_due.push_back(pend);
		end
	endtask

	task automatic check_result();
		stream_out_t want;
		if (out_due.size() == 0) begin
			log_mismatch($sformatf("unexpected transaction data %h end %b last %b",
				m_axis_tdata, m_axis_tuser, m_axis_tlast));
			return;
		end
		want = out_due[0];
		out_due.delete(0);
		if (m_axis_tdata !== want.data)
			log_mismatch($sformatf("out_byte %h, expected %h", m_axis_tdata, want.data));
		if (m_axis_tuser[0] !== want.is_end)
			log_mismatch($sformatf("is_end %b, expected %b", m_axis_tuser, want.is_end));
		if (m_axis_tlast !== want.last)
			log_mismatch($sformatf("last %b, expected %b", m_axis_tlast, want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				slot_byte[k] = '0;
				slot_full[k] = 1'b0;
			end
			next_pos = '0;
			win_limit = '0;
			end_pos = '0;
			end_known = 1'b0;
			closed = 1'b0;
			out_due.delete();
			mismatches = 0;
			awaited <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (s_axis_tvalid && s_axis_tready)
				reassemble(s_axis_tdata[IDX_W-1:0], s_axis_tdata[VAL_LO +: BYTE_W],
					s_axis_tuser[TU_FIRST], s_axis_tlast, s_axis_tuser[TU_NODATA],
					s_axis_tuser[TU_EOF], s_axis_tdata[HELD_LO +: HELD_W]);
			awaited <= out_due.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsr_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CHUNK  = 3;
	localparam int HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// byte_index, byte_value, stream_held, zero pad
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	// first_of_segment, no_data, eof_flag
	logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// out_byte
	logic [BYTE_W-1:0]     m_axis_tdata;
	// is_end
	logic [0:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	int                    mismatches;
	int                    awaited;
	int                    cycle_count = 0;
	int                    chunk_count = 0;
	int                    chunk_items = 0;
	bit                    steady = 1'b0;
	logic [IDX_W-1:0]      stream_base = '0;
	logic [IDX_W-1:0]      chunk_base = '0;
	logic [BYTE_W-1:0]     chunk_bytes [64];

	tcp_stream_reassembler_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	tsr_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.awaited       (awaited)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// sink side, with one long hold-off so the core backs up
	initial begin
		bit held_once;
		held_once = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_once && chunk_count == HOLD_CHUNK) begin
				held_once = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= steady || ($urandom_range(99) >= 34);
			end
		end
	end

	task automatic send_item(
		input logic [IDX_W-1:0]  idx,
		input logic [BYTE_W-1:0] val,
		input bit                first,
		input bit                seg_end,
		input bit                no_byte,
		input bit                eof,
		input logic [HELD_W-1:0] held
	);
		logic [IN_TUSER_W-1:0] tu;
		tu = '0;
		tu[TU_FIRST] = first;
		tu[TU_NODATA] = no_byte;
		tu[TU_EOF] = eof;
		while (!steady && $urandom_range(99) < 34) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, held, val, idx};
		s_axis_tuser <= tu;
		s_axis_tlast <= seg_end;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_segment(
		input logic [IDX_W-1:0]  start,
		input int                count,
		input bit                with_first,
		input bit                fresh,
		input logic [HELD_W-1:0] held,
		input bit                eof_last
	);
		logic [BYTE_W-1:0] val;
		bit                tail;
		for (int i = 0; i < count; i++) begin
			tail = (i == count - 1);
			val = fresh ? 8'($urandom) : chunk_bytes[int'(start - chunk_base) + i];
			// eof away from the segment end and held past the first item are don't-cares
			send_item(start + i, val, with_first && i == 0, tail, 1'b0,
				tail ? eof_last : 1'($urandom_range(1)),
				(i == 0) ? held : 7'($urandom_range(64)));
		end
	endtask

	// one contiguous stretch from stream_base, cut into segments and sent shuffled
	task automatic send_chunk(input int len);
		int               nseg;
		int               total;
		int               pick;
		int               tmp;
		int               seg_start [6];
		int               seg_len [6];
		int               order [6];
		logic [HELD_W-1:0] held;
		chunk_base = stream_base;
		for (int k = 0; k < len; k++)
			chunk_bytes[k] = 8'($urandom);
		nseg = $urandom_range(1, (len < 4) ? len : 4);
		seg_start[0] = 0;
		for (int k = 1; k < nseg; k++)
			seg_start[k] = seg_start[k-1]
				+ $urandom_range(1, len - seg_start[k-1] - (nseg - k));
		for (int k = 0; k < nseg; k++)
			seg_len[k] = ((k == nseg - 1) ? len : seg_start[k+1]) - seg_start[k];
		total = nseg;
		// overlapping resend with different payload, sent shuffled: whichever write came first must win
		if ($urandom_range(99) < 35) begin
			seg_start[total] = $urandom_range(0, len - 1);
			seg_len[total] = $urandom_range(1, len - seg_start[total]);
			total++;
		end
		for (int k = 0; k < total; k++)
			order[k] = k;
		for (int k = total - 1; k > 0; k--) begin
			pick = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[pick];
			order[pick] = tmp;
		end
		for (int p = 0; p < total; p++) begin
			held = HELD_W'($urandom_range(0, 64 - len));
			send_segment(stream_base + seg_start[order[p]], seg_len[order[p]],
				p == 0 || $urandom_range(9) != 0, order[p] == nseg, held, 1'b0);
		end
		stream_base += len;
		chunk_items += len;
		chunk_count++;
	endtask

	// items that the core has to drop
	task automatic send_noise();
		logic [IDX_W-1:0] idx;
		int               span;
		case ($urandom_range(3))
			0: begin
				span = (stream_base < 64) ? int'(stream_base) : 64;
				idx = stream_base - $urandom_range(1, span);
				send_item(idx, 8'($urandom), 1'b1, 1'b1, 1'b0, 1'b0, 7'($urandom_range(64)));
			end
			1: begin
				idx = {$urandom, $urandom} | (64'h1 << 40);
				send_item(idx, 8'($urandom), 1'($urandom_range(1)), 1'b1,
					1'($urandom_range(1)), 1'($urandom_range(1)), 7'($urandom_range(64)));
			end
			2: begin
				idx = stream_base + $urandom_range(63);
				send_item(idx, 8'($urandom), 1'b1, 1'b1, 1'b0, 1'b0, 7'd64);
			end
			default: begin
				idx = stream_base + $urandom_range(70);
				send_item(idx, 8'($urandom), 1'b1, 1'b1, 1'b1, 1'b0, 7'($urandom_range(64)));
			end
		endcase
	endtask

	initial begin
		int len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty segment at the stream start
		send_item(64'd0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 7'd0);
		// in order, payload extremes
		send_item(64'd0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
		send_item(64'd1, 8'hff, 1'b0, 1'b0, 1'b0, 1'b1, 7'd64);
		send_item(64'd2, 8'h5a, 1'b0, 1'b1, 1'b0, 1'b0, 7'd63);
		// below the next position
		send_item(64'd1, 8'h33, 1'b1, 1'b1, 1'b0, 1'b0, 7'd0);
		// window shut by held bytes, then a segment with no first item
		send_item(64'd3, 8'h44, 1'b1, 1'b1, 1'b0, 1'b0, 7'd64);
		send_item(64'd3, 8'h55, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
		// window of three, fourth byte falls off the end
		send_item(64'd3, 8'h81, 1'b1, 1'b0, 1'b0, 1'b0, 7'd61);
		send_item(64'd4, 8'h7e, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		send_item(64'd5, 8'hc3, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		send_item(64'd6, 8'h3c, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
		// out of order with an overlap, released together
		send_item(64'd8, 8'h18, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
		send_item(64'd9, 8'h19, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
		send_item(64'd7, 8'h17, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
		send_item(64'd8, 8'hee, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
		send_item(64'd6, 8'h16, 1'b1, 1'b1, 1'b0, 1'b0, 7'd0);
		// end of stream at the top of the index range, empty and with a byte
		send_item('1, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 7'd0);
		send_item('1, 8'haa, 1'b1, 1'b1, 1'b0, 1'b1, 7'd0);
		// last slot inside the window, then just past it
		send_item(64'd73, 8'h49, 1'b1, 1'b1, 1'b0, 1'b0, 7'd0);
		send_item(64'd74, 8'h4a, 1'b1, 1'b1, 1'b0, 1'b0, 7'd0);
		stream_base = 64'd10;

		while (chunk_items < 300) begin
			steady = (chunk_count >= 5 && chunk_count < 10);
			if ($urandom_range(99) < 15) begin
				send_noise();
			end else begin
				len = ($urandom_range(19) == 0) ? 64 : $urandom_range(1, 40);
				send_chunk(len);
			end
		end
		steady = 1'b0;

		// full-capacity release with the end reached: notice has to wait
		chunk_base = stream_base;
		for (int k = 0; k < 64; k++)
			chunk_bytes[k] = 8'($urandom);
		send_segment(stream_base + 1, 63, 1'b1, 1'b0, 7'd0, 1'b1);
		send_segment(stream_base, 1, 1'b1, 1'b0, 7'd0, 1'b0);
		stream_base += 64;
		send_item(stream_base, 8'($urandom), 1'b1, 1'b1, 1'b1, 1'b0, 7'd0);
		// traffic after the end notice
		send_chunk($urandom_range(1, 20));
		send_chunk($urandom_range(1, 20));

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (awaited != 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
